// ===== rtl/core/edge_filter_3x3_macros.svh =====
// Assertion macros for the edge_filter_3x3 RTL.
// Expects aclk and aresetn in the scope of the module that uses them.
`ifndef EDGE_FILTER_3X3_MACROS_SVH
`define EDGE_FILTER_3X3_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, held off during reset.
`define EF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("edge_filter_3x3: check failed");
// Next-cycle implication, held off during reset.
`define EF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("edge_filter_3x3: check failed");
`else
`define EF_ASSERT_IMPL(lbl, ante, cons)
`define EF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/ef3_pkg.sv =====
// Shared types and constants of the 3x3 edge filter.
// No dependencies.
`timescale 1ns / 1ps

package ef3_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 11;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // result queue, kept a power of two so the pointers wrap on their own
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

    // scaling: 2*127 ahead of the halving, 10*127 ahead of the 0.3 scaling
    localparam logic [11:0] LAP_OFFSET  = 12'd254;
    localparam logic [13:0] SOB_OFFSET  = 14'd1270;
    localparam logic [12:0] SOB_SAT     = 13'd2560;   // tx/10 reaches 256 here
    localparam logic [24:0] DIV10_RECIP = 25'd6554;   // ceil(2^16/10), exact below 2560

    typedef logic [PIX_W-1:0]   pixel_t;
    typedef logic [COORD_W-1:0] coord_t;

    // one queue entry: everything the up to three results of one pixel need
    typedef struct packed {
        coord_t     row;        // row of the input pixel
        coord_t     col;        // column of the input pixel
        coord_t     last_col;   // width minus one
        pixel_t     lap;        // first result, border case already folded in
        pixel_t     sob_h;
        pixel_t     sob_v;
        pixel_t     edge_val;   // row-end pixel of the row above
        pixel_t     pix;        // the input pixel itself
        logic [2:0] emit;       // bit 0 centre, bit 1 row end, bit 2 last row
        logic       done;
    } entry_t;

endpackage

// ===== rtl/core/edge_filter_3x3.sv =====
// Streaming 3x3 Laplacian / Sobel edge filter, top level.
// Uses ef3_pkg and edge_filter_3x3_macros.svh.
//
//   channel   dir  handshake          payload
//   --------  ---  -----------------  ---------------------------------------------
//   config    in   cfg_wr_en          cfg_index, cfg_wdata (width, height)
//   pixels    in   s_valid / s_ready  s_pixel
//   results   out  m_valid / m_ready  m_out_row, m_out_col, m_laplacian,
//                                     m_sobel_horizontal, m_sobel_vertical,
//                                     m_frame_done
//
// Cycles: one pixel per clock while each pixel yields at most one result and m_ready
//   stays high; on the last row and at row ends a pixel can yield two or three, and
//   the result port, one beat per clock while m_ready is high, sets the pace. On the way
//   to its first result beat a pixel passes line memory read, window and sums, scaling.
// s_ready drops only when the eight-entry result queue, counted with the pixels
//   still in flight, is full.
// Reset: control, counters and window cleared; the two line memories are not
//   cleared and need no clearing pass, a row is always written before it is read.
// A configuration write restarts the frame at row 0, column 0.
`timescale 1ns / 1ps
`include "edge_filter_3x3_macros.svh"

module edge_filter_3x3 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_wr_en,
    input  logic [ef3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ef3_pkg::CFG_W-1:0]      cfg_wdata,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ef3_pkg::PIX_W-1:0]      s_pixel,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ef3_pkg::COORD_W-1:0]    m_out_row,
    output logic [ef3_pkg::COORD_W-1:0]    m_out_col,
    output logic [ef3_pkg::PIX_W-1:0]      m_laplacian,
    output logic [ef3_pkg::PIX_W-1:0]      m_sobel_horizontal,
    output logic [ef3_pkg::PIX_W-1:0]      m_sobel_vertical,
    output logic                           m_frame_done
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CMP_WC = (CW + 1 > ef3_pkg::CFG_W) ? CW + 1 : ef3_pkg::CFG_W;
    localparam int CMP_WR = (RW + 1 > ef3_pkg::CFG_W) ? RW + 1 : ef3_pkg::CFG_W;
    localparam int W_RST = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
    localparam int H_RST = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;

    // ------------------------------------------------------------------
    // Geometry, held as width-1 / height-1 after zero and bound handling
    // ------------------------------------------------------------------
    logic [CW-1:0] wm1_reg, wm1_next, wm1_cfg;
    logic [RW-1:0] hm1_reg, hm1_next, hm1_cfg;

    always_comb begin
        if (cfg_wdata == '0) begin
            wm1_cfg = '0;
        end else if (CMP_WC'(cfg_wdata) > CMP_WC'(MAX_WIDTH)) begin
            wm1_cfg = CW'(MAX_WIDTH - 1);
        end else begin
            wm1_cfg = CW'(cfg_wdata - 12'd1);
        end
        if (cfg_wdata == '0) begin
            hm1_cfg = '0;
        end else if (CMP_WR'(cfg_wdata) > CMP_WR'(MAX_HEIGHT)) begin
            hm1_cfg = RW'(MAX_HEIGHT - 1);
        end else begin
            hm1_cfg = RW'(cfg_wdata - 12'd1);
        end
        wm1_next = wm1_reg;
        hm1_next = hm1_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                ef3_pkg::REG_FRAME_WIDTH:  wm1_next = wm1_cfg;
                ef3_pkg::REG_FRAME_HEIGHT: hm1_next = hm1_cfg;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side: position counters and what each pixel will emit
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [ef3_pkg::PEND_W-1:0] pend_reg, pend_next;

    logic s_accept, m_accept, pop;
    logic col_last, row_last, emit_centre, emit_rowend, emit_self, interior, emits_any;

    assign s_ready  = (pend_reg < ef3_pkg::PEND_W'(ef3_pkg::FIFO_DEPTH));
    assign s_accept = s_valid && s_ready;

    always_comb begin
        col_last    = (col_reg == wm1_reg);
        row_last    = (row_reg == hm1_reg);
        emit_centre = (row_reg != '0) && (col_reg != '0);
        emit_rowend = (row_reg != '0) && col_last;
        emit_self   = row_last;
        interior    = (row_reg > RW'(1)) && (col_reg > CW'(1));
        emits_any   = emit_centre || emit_rowend || emit_self;

        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr_en) begin
            col_next = '0;
            row_next = '0;
        end else if (s_accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : RW'(row_reg + 1'b1);
            end else begin
                col_next = CW'(col_reg + 1'b1);
            end
        end

        // items owed to the queue: counted at the pixel beat, released at its last result
        pend_next = pend_reg;
        if (s_accept && emits_any && !pop) begin
            pend_next = ef3_pkg::PEND_W'(pend_reg + 1'b1);
        end else if (pop && !(s_accept && emits_any)) begin
            pend_next = ef3_pkg::PEND_W'(pend_reg - 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line memory read data, window shift, memory write-back
    // ------------------------------------------------------------------
    logic [ef3_pkg::PIX_W-1:0] older_mem [MAX_WIDTH];
    logic [ef3_pkg::PIX_W-1:0] newer_mem [MAX_WIDTH];

    logic                  s1_valid_reg;
    ef3_pkg::pixel_t       s1_pix_reg, older_rd_reg, newer_rd_reg;
    ef3_pkg::pixel_t       s1_fwd_older_reg, s1_fwd_newer_reg;
    logic                  s1_fwd_reg;
    logic [CW-1:0]         s1_col_reg;
    ef3_pkg::coord_t       s1_row_reg, s1_col11_reg;
    logic [2:0]            s1_emit_reg;
    logic                  s1_interior_reg, s1_done_reg;

    ef3_pkg::pixel_t win_reg  [3][3];
    ef3_pkg::pixel_t win_next [3][3];
    ef3_pkg::pixel_t old_col, new_col;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            older_rd_reg     <= older_mem[col_reg];
            newer_rd_reg     <= newer_mem[col_reg];
            // same column being written back this edge: take the new values
            s1_fwd_reg       <= s1_valid_reg && (s1_col_reg == col_reg);
            s1_fwd_older_reg <= new_col;
            s1_fwd_newer_reg <= s1_pix_reg;
            s1_pix_reg       <= s_pixel;
            s1_col_reg       <= col_reg;
            s1_row_reg       <= ef3_pkg::COORD_W'(row_reg);
            s1_col11_reg     <= ef3_pkg::COORD_W'(col_reg);
            s1_emit_reg      <= {emit_self, emit_rowend, emit_centre};
            s1_interior_reg  <= interior;
            s1_done_reg      <= emit_self && col_last;
        end
        if (s1_valid_reg) begin
            older_mem[s1_col_reg] <= new_col;
            newer_mem[s1_col_reg] <= s1_pix_reg;
        end
    end

    // sums taken from the shifted window
    logic [9:0]  lap_sum4, gx_pos, gx_neg, gy_pos, gy_neg;
    logic [11:0] gx_pos3, gx_neg3, gy_pos3, gy_neg3, tl_next;
    logic [13:0] tx_next, ty_next;

    always_comb begin
        old_col = s1_fwd_reg ? s1_fwd_older_reg : older_rd_reg;
        new_col = s1_fwd_reg ? s1_fwd_newer_reg : newer_rd_reg;
        for (int i = 0; i < 3; i++) begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = old_col;
        win_next[1][2] = new_col;
        win_next[2][2] = s1_pix_reg;

        lap_sum4 = 10'(win_next[0][1]) + 10'(win_next[2][1])
                 + 10'(win_next[1][0]) + 10'(win_next[1][2]);
        tl_next  = ef3_pkg::LAP_OFFSET + 12'(lap_sum4) - 12'({win_next[1][1], 2'b00});

        gx_pos = 10'(win_next[0][2]) + 10'({win_next[1][2], 1'b0}) + 10'(win_next[2][2]);
        gx_neg = 10'(win_next[0][0]) + 10'({win_next[1][0], 1'b0}) + 10'(win_next[2][0]);
        gy_pos = 10'(win_next[2][0]) + 10'({win_next[2][1], 1'b0}) + 10'(win_next[2][2]);
        gy_neg = 10'(win_next[0][0]) + 10'({win_next[0][1], 1'b0}) + 10'(win_next[0][2]);
        gx_pos3 = 12'(gx_pos) + 12'({gx_pos, 1'b0});
        gx_neg3 = 12'(gx_neg) + 12'({gx_neg, 1'b0});
        gy_pos3 = 12'(gy_pos) + 12'({gy_pos, 1'b0});
        gy_neg3 = 12'(gy_neg) + 12'({gy_neg, 1'b0});
        tx_next = ef3_pkg::SOB_OFFSET + 14'(gx_pos3) - 14'(gx_neg3);
        ty_next = ef3_pkg::SOB_OFFSET + 14'(gy_pos3) - 14'(gy_neg3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (s1_valid_reg) begin
            win_reg <= win_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: clamping and the divide by ten, then into the queue
    // ------------------------------------------------------------------
    logic                  s2_valid_reg;
    logic [11:0]           s2_tl_reg;
    logic [13:0]           s2_tx_reg, s2_ty_reg;
    ef3_pkg::pixel_t       s2_ctr_reg, s2_edge_reg, s2_pix_reg;
    ef3_pkg::coord_t       s2_row_reg, s2_col_reg;
    logic [2:0]            s2_emit_reg;
    logic                  s2_interior_reg, s2_done_reg;

    always_ff @(posedge aclk) begin
        s2_tl_reg       <= tl_next;
        s2_tx_reg       <= tx_next;
        s2_ty_reg       <= ty_next;
        s2_ctr_reg      <= win_next[1][1];
        s2_edge_reg     <= new_col;
        s2_pix_reg      <= s1_pix_reg;
        s2_row_reg      <= s1_row_reg;
        s2_col_reg      <= s1_col11_reg;
        s2_emit_reg     <= s1_emit_reg;
        s2_interior_reg <= s1_interior_reg;
        s2_done_reg     <= s1_done_reg;
    end

    logic [24:0]     prod_x, prod_y;
    ef3_pkg::pixel_t lap_val, sob_h_val, sob_v_val;
    ef3_pkg::entry_t push_entry;

    always_comb begin
        prod_x = 25'(s2_tx_reg[11:0]) * ef3_pkg::DIV10_RECIP;
        prod_y = 25'(s2_ty_reg[11:0]) * ef3_pkg::DIV10_RECIP;

        if (s2_tl_reg[11]) begin
            lap_val = '0;
        end else if (s2_tl_reg[10:9] != 2'b00) begin
            lap_val = '1;
        end else begin
            lap_val = s2_tl_reg[8:1];
        end
        if (s2_tx_reg[13]) begin
            sob_h_val = '0;
        end else if (s2_tx_reg[12:0] >= ef3_pkg::SOB_SAT) begin
            sob_h_val = '1;
        end else begin
            sob_h_val = prod_x[23:16];
        end
        if (s2_ty_reg[13]) begin
            sob_v_val = '0;
        end else if (s2_ty_reg[12:0] >= ef3_pkg::SOB_SAT) begin
            sob_v_val = '1;
        end else begin
            sob_v_val = prod_y[23:16];
        end

        push_entry.row      = s2_row_reg;
        push_entry.col      = s2_col_reg;
        push_entry.last_col = ef3_pkg::COORD_W'(wm1_reg);
        // border pixels pass the centre straight through
        push_entry.lap      = s2_interior_reg ? lap_val   : s2_ctr_reg;
        push_entry.sob_h    = s2_interior_reg ? sob_h_val : s2_ctr_reg;
        push_entry.sob_v    = s2_interior_reg ? sob_v_val : s2_ctr_reg;
        push_entry.edge_val = s2_edge_reg;
        push_entry.pix      = s2_pix_reg;
        push_entry.emit     = s2_emit_reg;
        push_entry.done     = s2_done_reg;
    end

    // ------------------------------------------------------------------
    // Result queue and output sequencing
    // ------------------------------------------------------------------
    ef3_pkg::entry_t                  fifo_mem [ef3_pkg::FIFO_DEPTH];
    logic [ef3_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [ef3_pkg::PEND_W-1:0]       fifo_cnt_reg, fifo_cnt_next;
    logic [2:0]                       taken_reg, taken_next;
    logic [2:0]                       remain, cur_sel;
    logic                             push, last_beat;
    ef3_pkg::entry_t                  head;

    assign push = s2_valid_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_comb begin
        head      = fifo_mem[rd_ptr_reg];
        remain    = head.emit & ~taken_reg;
        cur_sel   = {remain[2] & ~remain[1] & ~remain[0], remain[1] & ~remain[0], remain[0]};
        last_beat = ((remain & ~cur_sel) == 3'b000);

        m_valid  = (fifo_cnt_reg != '0);
        m_accept = m_valid && m_ready;
        pop      = m_accept && last_beat;

        m_out_row          = head.row;
        m_out_col          = head.col;
        m_laplacian        = head.pix;
        m_sobel_horizontal = head.pix;
        m_sobel_vertical   = head.pix;
        m_frame_done       = head.done;
        case (cur_sel)
            3'b001: begin
                m_out_row          = ef3_pkg::COORD_W'(head.row - 1'b1);
                m_out_col          = ef3_pkg::COORD_W'(head.col - 1'b1);
                m_laplacian        = head.lap;
                m_sobel_horizontal = head.sob_h;
                m_sobel_vertical   = head.sob_v;
                m_frame_done       = 1'b0;
            end
            3'b010: begin
                m_out_row          = ef3_pkg::COORD_W'(head.row - 1'b1);
                m_out_col          = head.last_col;
                m_laplacian        = head.edge_val;
                m_sobel_horizontal = head.edge_val;
                m_sobel_vertical   = head.edge_val;
                m_frame_done       = 1'b0;
            end
            default: ;  // the pixel itself, on the last row
        endcase

        taken_next = taken_reg;
        if (pop) begin
            taken_next = '0;
        end else if (m_accept) begin
            taken_next = taken_reg | cur_sel;
        end

        wr_ptr_next = push ? ef3_pkg::FIFO_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? ef3_pkg::FIFO_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fifo_cnt_next = fifo_cnt_reg;
        if (push && !pop) begin
            fifo_cnt_next = ef3_pkg::PEND_W'(fifo_cnt_reg + 1'b1);
        end else if (pop && !push) begin
            fifo_cnt_next = ef3_pkg::PEND_W'(fifo_cnt_reg - 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wm1_reg      <= CW'(W_RST - 1);
            hm1_reg      <= RW'(H_RST - 1);
            col_reg      <= '0;
            row_reg      <= '0;
            pend_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            taken_reg    <= '0;
        end else begin
            wm1_reg      <= wm1_next;
            hm1_reg      <= hm1_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            pend_reg     <= pend_next;
            s1_valid_reg <= s_accept;
            s2_valid_reg <= s1_valid_reg && (s1_emit_reg != 3'b000);
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            fifo_cnt_reg <= fifo_cnt_next;
            taken_reg    <= taken_next;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `EF_ASSERT_IMPL(a_pend_bound, 1'b1, pend_reg <= ef3_pkg::PEND_W'(ef3_pkg::FIFO_DEPTH))
    `EF_ASSERT_IMPL(a_queue_within_pend, 1'b1, fifo_cnt_reg <= pend_reg)
    `EF_ASSERT_IMPL(a_head_has_result, m_valid, $onehot(cur_sel))
    `EF_ASSERT_IMPL(a_taken_clear_when_empty, fifo_cnt_reg == '0, taken_reg == 3'b000)
    `EF_ASSERT_NEXT(a_beat_enters_stage1, s_accept, s1_valid_reg)

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the streaming 3x3 Laplacian / Sobel edge filter.
// Depends on ef3_pkg and the edge_filter_3x3 top level; reads no files.
`timescale 1ns / 1ps

module testbench;

    localparam int LINE_DEPTH    = 2048;   // matches the default MAX_WIDTH / MAX_HEIGHT
    localparam int STALL_LIMIT   = 2000;   // cycles without any beat before giving up
    localparam int SETTLE_CYCLES = 8;      // pipeline is three deep, leave some slack
    localparam int ITEM_TARGET   = 410;    // pixel beats over the whole run
    localparam int MAX_GAP       = 12;

    // pixel content styles for a phase
    localparam int STYLE_UNIFORM  = 0;
    localparam int STYLE_EXTREMES = 1;
    localparam int STYLE_SMOOTH   = 2;

    typedef struct packed {
        ef3_pkg::coord_t row;
        ef3_pkg::coord_t col;
        ef3_pkg::pixel_t lap;
        ef3_pkg::pixel_t grad_x;
        ef3_pkg::pixel_t grad_y;
        logic            done;
    } result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          cfg_wr_en = 1'b0;
    logic [ef3_pkg::CFG_IDX_W-1:0] cfg_index = ef3_pkg::REG_FRAME_WIDTH;
    logic [ef3_pkg::CFG_W-1:0]     cfg_wdata = '0;

    logic            s_valid = 1'b0;
    logic            s_ready;
    ef3_pkg::pixel_t s_pixel = '0;

    logic            m_valid;
    logic            m_ready = 1'b0;
    ef3_pkg::coord_t m_out_row;
    ef3_pkg::coord_t m_out_col;
    ef3_pkg::pixel_t m_laplacian;
    ef3_pkg::pixel_t m_sobel_horizontal;
    ef3_pkg::pixel_t m_sobel_vertical;
    logic            m_frame_done;

    edge_filter_3x3 u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_pixel            (s_pixel),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_row          (m_out_row),
        .m_out_col          (m_out_col),
        .m_laplacian        (m_laplacian),
        .m_sobel_horizontal (m_sobel_horizontal),
        .m_sobel_vertical   (m_sobel_vertical),
        .m_frame_done       (m_frame_done)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow of the filter: geometry registers, line stores, window and
    // raster position, advanced once per accepted pixel beat.
    // ------------------------------------------------------------------
    logic [ef3_pkg::CFG_W-1:0] width_reg  = 12'd640;
    logic [ef3_pkg::CFG_W-1:0] height_reg = 12'd480;
    ef3_pkg::pixel_t           upper_line [LINE_DEPTH];
    ef3_pkg::pixel_t           lower_line [LINE_DEPTH];
    ef3_pkg::pixel_t           win [9];
    int                        row_pos = 0;
    int                        col_pos = 0;

    result_t         pending_results[$];   // expected result beats, oldest first
    ef3_pkg::pixel_t pixel_feed[$];        // pixels waiting for the driver

    int  err_count   = 0;
    int  n_pixels    = 0;
    int  n_results   = 0;
    int  n_frames    = 0;
    int  n_phases    = 0;
    bit  src_idle_on = 1'b0;
    bit  dst_idle_on = 1'b0;

    initial begin
        foreach (upper_line[i]) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
    end

    // zero reads as one, anything past the line store saturates
    function automatic int geometry(input logic [ef3_pkg::CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > LINE_DEPTH) return LINE_DEPTH;
        return int'(v);
    endfunction

    function automatic ef3_pkg::pixel_t sat_byte(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return ef3_pkg::pixel_t'(v);
    endfunction

    function automatic result_t flat_result(input int r, input int c,
                                            input ef3_pkg::pixel_t v, input logic done);
        return '{ef3_pkg::coord_t'(r), ef3_pkg::coord_t'(c), v, v, v, done};
    endfunction

    // One pixel through the shadow filter; queues the up to three results it releases:
    // the centre of the window, the row-end pixel of the row above, and on the last
    // row the pixel itself.
    task automatic filter_pixel(input ef3_pkg::pixel_t p);
        int wd, ht, r, c, i;
        int s, gx, gy, tl, tx, ty;
        result_t res;
        wd = geometry(width_reg);
        ht = geometry(height_reg);
        r  = row_pos;
        c  = col_pos;
        for (i = 0; i < 3; i++) begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = upper_line[c];
        win[5] = lower_line[c];
        win[8] = p;
        upper_line[c] = lower_line[c];
        lower_line[c] = p;

        if (r >= 1 && c >= 1) begin
            if (r >= 2 && c >= 2) begin
                s  = win[1] + win[7] + win[3] + win[5] - 4 * win[4];
                gx = (win[2] + 2 * win[5] + win[8]) - (win[0] + 2 * win[3] + win[6]);
                gy = (win[6] + 2 * win[7] + win[8]) - (win[0] + 2 * win[1] + win[2]);
                tl = 254 + s;
                tx = 1270 + 3 * gx;
                ty = 1270 + 3 * gy;
                res = '{ef3_pkg::coord_t'(r - 1), ef3_pkg::coord_t'(c - 1),
                        sat_byte(tl < 0 ? 0 : tl / 2),
                        sat_byte(tx < 0 ? 0 : tx / 10),
                        sat_byte(ty < 0 ? 0 : ty / 10), 1'b0};
            end else begin
                // first interior row or column: centre passes straight through
                res = flat_result(r - 1, c - 1, win[4], 1'b0);
            end
            pending_results.push_back(res);
        end
        if (r >= 1 && c == wd - 1)
            pending_results.push_back(flat_result(r - 1, wd - 1, win[5], 1'b0));
        if (r == ht - 1)
            pending_results.push_back(flat_result(r, c, p, c == wd - 1));

        if (c + 1 >= wd) begin
            col_pos = 0;
            row_pos = (r + 1 >= ht) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic log_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Pixel driver: one beat per entry of pixel_feed; with src_idle_on a random gap
    // is drawn after each beat is issued.
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                filter_pixel(s_pixel);
                n_pixels++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pixel_feed.size() != 0) begin
                    s_valid  <= 1'b1;
                    s_pixel  <= pixel_feed.pop_front();
                    gap_left = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks every accepted beat against the oldest
    // expectation, then, with dst_idle_on, holds ready low for a random stall.
    // ------------------------------------------------------------------
    int      hold_left = 0;
    result_t got_res;
    result_t want_res;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                got_res = '{m_out_row, m_out_col, m_laplacian, m_sobel_horizontal,
                            m_sobel_vertical, m_frame_done};
                if (pending_results.size() == 0) begin
                    log_mismatch($sformatf("unexpected beat at (%0d,%0d)",
                                           m_out_row, m_out_col));
                end else begin
                    want_res = pending_results.pop_front();
                    if (got_res !== want_res)
                        log_mismatch({
                            $sformatf("got (%0d,%0d) lap %0d h %0d v %0d done %0d",
                                      got_res.row, got_res.col, got_res.lap,
                                      got_res.grad_x, got_res.grad_y, got_res.done),
                            $sformatf(", want (%0d,%0d) lap %0d h %0d v %0d done %0d",
                                      want_res.row, want_res.col, want_res.lap,
                                      want_res.grad_x, want_res.grad_y, want_res.done)});
                end
                n_results++;
                if (m_frame_done) n_frames++;
                hold_left = dst_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            m_ready <= (hold_left == 0);
        end
    end

    // watchdog: any beat or register write counts as progress
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // register write: enable high for one edge; the shadow follows at that edge
    task automatic write_reg(input logic [ef3_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ef3_pkg::CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == ef3_pkg::REG_FRAME_WIDTH)
            width_reg = val;
        else if (idx == ef3_pkg::REG_FRAME_HEIGHT)
            height_reg = val;
        row_pos = 0;
        col_pos = 0;
    endtask

    // wait for the block to go quiet so a register write cannot hit work in flight
    task automatic settle();
        do @(negedge aclk);
        while (pixel_feed.size() != 0 || s_valid || pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic ef3_pkg::pixel_t draw_pixel(input int style, input int base);
        case (style)
            STYLE_EXTREMES: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            STYLE_SMOOTH:   return sat_byte(base + int'($urandom_range(0, 16)) - 8);
            default:        return ef3_pkg::pixel_t'($urandom_range(0, 255));
        endcase
    endfunction

    // One random phase. A negative register value leaves that register alone.
    task automatic run_phase(input int w_val, input int h_val, input int count,
                             input int style);
        int base, i;
        base = $urandom_range(0, 255);
        if (w_val >= 0) write_reg(ef3_pkg::REG_FRAME_WIDTH, ef3_pkg::CFG_W'(w_val));
        if (h_val >= 0) write_reg(ef3_pkg::REG_FRAME_HEIGHT, ef3_pkg::CFG_W'(h_val));
        @(negedge aclk);
        // each side runs flat out in about one phase out of four
        src_idle_on = ($urandom_range(0, 3) != 0);
        dst_idle_on = ($urandom_range(0, 3) != 0);
        for (i = 0; i < count; i++) pixel_feed.push_back(draw_pixel(style, base));
        n_phases++;
        settle();
    endtask

    initial begin
        int idx, f, w, h, area, count, pick;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: two 3x3 frames, a bright corner and its negative, so that all
        // three outputs clamp both low and high on the single interior pixel.
        write_reg(ef3_pkg::REG_FRAME_WIDTH, 12'd3);
        write_reg(ef3_pkg::REG_FRAME_HEIGHT, 12'd3);
        @(negedge aclk);
        src_idle_on = 1'b1;
        dst_idle_on = 1'b1;
        for (f = 0; f < 2; f++)
            for (idx = 0; idx < 9; idx++)
                pixel_feed.push_back(((idx / 3 + idx % 3 >= 2) ^ (f == 1)) ? 8'd255 : 8'd0);
        n_phases++;
        settle();

        // zero geometry: 1x1 frames, every pixel closes its own frame
        write_reg(ef3_pkg::REG_FRAME_WIDTH, 12'd0);
        write_reg(ef3_pkg::REG_FRAME_HEIGHT, 12'd0);
        @(negedge aclk);
        pixel_feed.push_back(8'd0);
        pixel_feed.push_back(8'd255);
        pixel_feed.push_back(8'h5A);
        n_phases++;
        settle();

        // geometry extremes: oversize height saturates, so no frame end comes early
        run_phase(2, 4095, 12, STYLE_UNIFORM);
        // oversize width on a single row saturates, so no frame end inside the phase
        run_phase(4095, 1, 40, STYLE_UNIFORM);
        run_phase(2048, 1, 30, STYLE_UNIFORM);
        run_phase(1, 2048, 30, STYLE_SMOOTH);

        // Random phases: mostly small frames, whole frames with random content,
        // sometimes a trailing partial frame cut short by the next register write.
        while (n_pixels < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            w = (pick == 0) ? 0 : (pick == 1) ? 1 : $urandom_range(2, 8);
            pick = $urandom_range(0, 9);
            h = (pick == 0) ? 0 : (pick == 1) ? 1 : $urandom_range(2, 6);
            pick = $urandom_range(0, 7);
            if (pick == 0 && n_phases > 6) w = -1;
            if (pick == 1 && n_phases > 6) h = -1;
            area = geometry(w >= 0 ? ef3_pkg::CFG_W'(w) : width_reg)
                 * geometry(h >= 0 ? ef3_pkg::CFG_W'(h) : height_reg);
            count = area * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, area);
            if (count > 150) count = 150;
            if (count > ITEM_TARGET - n_pixels) count = ITEM_TARGET - n_pixels;
            run_phase(w, h, count, $urandom_range(STYLE_UNIFORM, STYLE_SMOOTH));
        end

        settle();
        $display("summary: %0d phases, %0d pixel beats in, %0d result beats checked",
                 n_phases, n_pixels, n_results);
        $display("summary: %0d frames closed, %0d mismatches", n_frames, err_count);
        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ef3_pkg.sv
rtl/core/edge_filter_3x3.sv
test/testbench.sv
